/* src/cr3_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cr3_pkg
// Widths, stage map and result codes shared by the 3x3 Cramer solver.
// ----------------------------------------------------------------------------
package cr3_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_WIDTH  = 32;
    localparam logic [CFG_WIDTH-1:0] THRESH_RESET = CFG_WIDTH'(281475);

    // Two-by-two minor, partial product and determinant widths.
    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int MIN_W  = 2 * DATA_WIDTH + 1;
    localparam int PART_W = 2 * DATA_WIDTH + 1;
    localparam int DET_W  = 3 * DATA_WIDTH + 2;
    localparam int MAG_W  = DET_W - 1;
    localparam int NUM_W  = MAG_W + FRAC_BITS;
    localparam int CMP_W  = MAG_W + DATA_WIDTH + 1;

    localparam logic [DATA_WIDTH-1:0] Q_HALF = DATA_WIDTH'(1) << (DATA_WIDTH - 1);

    // Pipeline stage map.
    localparam int DET_STAGES = 5;
    localparam int DIV_STAGES = DATA_WIDTH + 1;
    localparam int ST_IN      = 0;
    localparam int ST_DET0    = 1;
    localparam int ST_PREP    = ST_DET0 + DET_STAGES;
    localparam int ST_DIV0    = ST_PREP + 1;
    localparam int ST_DIVN    = ST_DIV0 + DIV_STAGES - 1;
    localparam int ST_OUT     = ST_DIVN + 1;
    localparam int N_ST       = ST_OUT + 1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_SINGULAR  = 2'd1,
        STATUS_SATURATED = 2'd2
    } solve_status_t;

endpackage
`default_nettype wire

/* src/cr3_det.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cr3_det
// Five-stage pipelined 3x3 determinant by cofactor expansion along row 0.
// ----------------------------------------------------------------------------
module cr3_det import cr3_pkg::*; (
    input  wire logic                          aclk,
    input  wire logic [DET_STAGES-1:0]         en,
    input  wire logic signed [DATA_WIDTH-1:0]  mat [9],
    output logic signed [DET_W-1:0]            det
);

    logic signed [PROD_W-1:0]     p_reg [6];
    logic signed [DATA_WIDTH-1:0] r0a_reg [3];
    logic signed [MIN_W-1:0]      minor_reg [3];
    logic signed [DATA_WIDTH-1:0] r0b_reg [3];
    logic signed [PART_W-1:0]     ph_reg [3];
    logic signed [PART_W-1:0]     pl_reg [3];
    logic signed [DET_W-1:0]      term_reg [3];
    logic signed [DET_W-1:0]      det_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            p_reg[0] <= mat[4] * mat[8];
            p_reg[1] <= mat[7] * mat[5];
            p_reg[2] <= mat[3] * mat[8];
            p_reg[3] <= mat[5] * mat[6];
            p_reg[4] <= mat[3] * mat[7];
            p_reg[5] <= mat[4] * mat[6];
            for (int i = 0; i < 3; i++) r0a_reg[i] <= mat[i];
        end
        if (en[1]) begin
            for (int i = 0; i < 3; i++) begin
                minor_reg[i] <= MIN_W'(p_reg[2*i]) - MIN_W'(p_reg[2*i+1]);
                r0b_reg[i]   <= r0a_reg[i];
            end
        end
        // The 65-bit minor is split so that no multiplier exceeds 32 by 33 bits.
        if (en[2]) begin
            for (int i = 0; i < 3; i++) begin
                ph_reg[i] <= r0b_reg[i] * $signed(minor_reg[i][MIN_W-1:DATA_WIDTH]);
                pl_reg[i] <= r0b_reg[i] * $signed({1'b0, minor_reg[i][DATA_WIDTH-1:0]});
            end
        end
        if (en[3]) begin
            for (int i = 0; i < 3; i++) begin
                term_reg[i] <= (DET_W'(ph_reg[i]) <<< DATA_WIDTH) + DET_W'(pl_reg[i]);
            end
        end
        if (en[4]) begin
            det_reg <= term_reg[0] - term_reg[1] + term_reg[2];
        end
    end

    assign det = det_reg;

endmodule
`default_nettype wire

/* src/cr3_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cr3_div
// Pipelined restoring divider: one range check stage, then one quotient bit
// per stage, most significant first.
// ----------------------------------------------------------------------------
module cr3_div import cr3_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic [DIV_STAGES-1:0]  en,
    input  wire logic [NUM_W-1:0]       num,
    input  wire logic [MAG_W-1:0]       den,
    input  wire logic                   neg,
    output logic [DATA_WIDTH-1:0]       quo,
    output logic                        ovf,
    output logic                        quo_neg
);

    logic [NUM_W-1:0]      rem_reg [DIV_STAGES];
    logic [MAG_W-1:0]      den_reg [DIV_STAGES];
    logic [DATA_WIDTH-1:0] q_reg   [DIV_STAGES];
    logic                  ovf_reg [DIV_STAGES];
    logic                  neg_reg [DIV_STAGES];

    // A quotient of 2^DATA_WIDTH or more saturates whatever its sign.
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg;
            ovf_reg[0] <= CMP_W'(num) >= (CMP_W'(den) << DATA_WIDTH);
        end
    end

    for (genvar j = 1; j < DIV_STAGES; j++) begin : g_bit
        logic [CMP_W-1:0] shifted;
        logic             ge;
        assign shifted = CMP_W'(den_reg[j-1]) << (DATA_WIDTH - j);
        assign ge      = CMP_W'(rem_reg[j-1]) >= shifted;

        always_ff @(posedge aclk) begin
            if (en[j]) begin
                rem_reg[j] <= ge ? NUM_W'(CMP_W'(rem_reg[j-1]) - shifted) : rem_reg[j-1];
                den_reg[j] <= den_reg[j-1];
                q_reg[j]   <= {q_reg[j-1][DATA_WIDTH-2:0], ge};
                ovf_reg[j] <= ovf_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
            end
        end
    end

    assign quo     = q_reg[DIV_STAGES-1];
    assign ovf     = ovf_reg[DIV_STAGES-1];
    assign quo_neg = neg_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

/* src/cramer_3x3_linear_solver.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cramer_3x3_linear_solver
// Solves A*x = b for one 3x3 system per transaction by Cramer's rule.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel carries the nine Q16.16 matrix entries and three right-hand
// values; the m_ channel returns the three Q16.16 unknowns and a status code
// (ok, singular, saturated). The cfg_ channel writes the singular threshold,
// compared against |det| at Q.48 scale; write it only while the block is idle.
// On its way to m_valid, the item passes one input stage, five determinant
// stages, one magnitude and threshold stage, 33 divider stages (range check
// and one quotient bit each) and the output register. Throughput is one
// transaction per cycle while m_ready keeps the output moving; the 32
// bit-serial divider stages per unknown set the depth. Every stage holds a
// valid bit and loads whenever it is empty or the stage after it moves, so
// bubbles close up and new transactions keep entering while a result waits
// on m_ready. When the receiver stalls and the pipeline is full, s_ready
// falls; nothing is lost or repeated. Synchronous reset clears all valid
// bits and restores the threshold to its reset value.
// ----------------------------------------------------------------------------
module cramer_3x3_linear_solver import cr3_pkg::*; (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CFG_WIDTH-1:0]          cfg_singular_threshold,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [DATA_WIDTH-1:0]  s_a_r0c0,
    input  wire logic signed [DATA_WIDTH-1:0]  s_a_r0c1,
    input  wire logic signed [DATA_WIDTH-1:0]  s_a_r0c2,
    input  wire logic signed [DATA_WIDTH-1:0]  s_a_r1c0,
    input  wire logic signed [DATA_WIDTH-1:0]  s_a_r1c1,
    input  wire logic signed [DATA_WIDTH-1:0]  s_a_r1c2,
    input  wire logic signed [DATA_WIDTH-1:0]  s_a_r2c0,
    input  wire logic signed [DATA_WIDTH-1:0]  s_a_r2c1,
    input  wire logic signed [DATA_WIDTH-1:0]  s_a_r2c2,
    input  wire logic signed [DATA_WIDTH-1:0]  s_rhs_0,
    input  wire logic signed [DATA_WIDTH-1:0]  s_rhs_1,
    input  wire logic signed [DATA_WIDTH-1:0]  s_rhs_2,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [DATA_WIDTH-1:0]       m_sol_0,
    output logic signed [DATA_WIDTH-1:0]       m_sol_1,
    output logic signed [DATA_WIDTH-1:0]       m_sol_2,
    output logic [1:0]                         m_solve_status
);

    logic [CFG_WIDTH-1:0]         thr_reg;
    logic [N_ST-1:0]              v_reg;
    logic [N_ST-1:0]              v_next;
    logic [N_ST-1:0]              en;

    logic signed [DATA_WIDTH-1:0] a_reg [9];
    logic signed [DATA_WIDTH-1:0] b_reg [3];
    logic signed [DATA_WIDTH-1:0] mk [4][9];
    logic signed [DET_W-1:0]      det_w [4];

    logic [MAG_W-1:0]             den_reg;
    logic [NUM_W-1:0]             num_reg [3];
    logic                         neg_reg [3];
    logic                         sing_reg [ST_PREP:ST_DIVN];

    logic [DATA_WIDTH-1:0]        quo_w [3];
    logic                         ovf_w [3];
    logic                         qneg_w [3];

    logic signed [DATA_WIDTH-1:0] sol_reg [3];
    logic signed [DATA_WIDTH-1:0] sol_next [3];
    solve_status_t                status_reg;
    solve_status_t                status_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THRESH_RESET;
        end else if (cfg_valid) begin
            thr_reg <= cfg_singular_threshold;
        end
    end

    // Each stage moves when it is empty or when the stage after it moves.
    always_comb begin
        en[N_ST-1] = !v_reg[N_ST-1] || m_ready;
        for (int i = N_ST - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next[0] = en[0] ? s_valid : v_reg[0];
        for (int i = 1; i < N_ST; i++) begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_ready = en[ST_IN];

    always_ff @(posedge aclk) begin
        if (en[ST_IN]) begin
            a_reg[0] <= s_a_r0c0;
            a_reg[1] <= s_a_r0c1;
            a_reg[2] <= s_a_r0c2;
            a_reg[3] <= s_a_r1c0;
            a_reg[4] <= s_a_r1c1;
            a_reg[5] <= s_a_r1c2;
            a_reg[6] <= s_a_r2c0;
            a_reg[7] <= s_a_r2c1;
            a_reg[8] <= s_a_r2c2;
            b_reg[0] <= s_rhs_0;
            b_reg[1] <= s_rhs_1;
            b_reg[2] <= s_rhs_2;
        end
    end

    // Slot 0 is A itself; slot k+1 is A with column k replaced by b.
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            mk[0][i] = a_reg[i];
        end
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 9; i++) begin
                mk[k+1][i] = ((i % 3) == k) ? b_reg[i / 3] : a_reg[i];
            end
        end
    end

    for (genvar d = 0; d < 4; d++) begin : g_det
        cr3_det u_det (
            .aclk (aclk),
            .en   (en[ST_DET0 +: DET_STAGES]),
            .mat  (mk[d]),
            .det  (det_w[d])
        );
    end

    always_ff @(posedge aclk) begin
        logic [DET_W-1:0] dabs;
        logic [DET_W-1:0] kabs;
        if (en[ST_PREP]) begin
            dabs = det_w[0][DET_W-1] ? DET_W'(-det_w[0]) : DET_W'(det_w[0]);
            den_reg           <= dabs[MAG_W-1:0];
            sing_reg[ST_PREP] <= (dabs == '0) || (dabs < DET_W'(thr_reg));
            for (int k = 0; k < 3; k++) begin
                kabs = det_w[k+1][DET_W-1] ? DET_W'(-det_w[k+1]) : DET_W'(det_w[k+1]);
                num_reg[k] <= {kabs[MAG_W-1:0], {FRAC_BITS{1'b0}}};
                neg_reg[k] <= det_w[k+1][DET_W-1] ^ det_w[0][DET_W-1];
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_div
        cr3_div u_div (
            .aclk    (aclk),
            .en      (en[ST_DIV0 +: DIV_STAGES]),
            .num     (num_reg[k]),
            .den     (den_reg),
            .neg     (neg_reg[k]),
            .quo     (quo_w[k]),
            .ovf     (ovf_w[k]),
            .quo_neg (qneg_w[k])
        );
    end

    for (genvar s = ST_DIV0; s <= ST_DIVN; s++) begin : g_sing
        always_ff @(posedge aclk) begin
            if (en[s]) begin
                sing_reg[s] <= sing_reg[s-1];
            end
        end
    end

    always_comb begin
        logic                  sat_any;
        logic                  sat;
        logic [DATA_WIDTH-1:0] mag;
        sat_any = 1'b0;
        for (int k = 0; k < 3; k++) begin
            sat = ovf_w[k] || (qneg_w[k] ? (quo_w[k] > Q_HALF) : (quo_w[k] > Q_HALF - 1'b1));
            mag = sat ? (qneg_w[k] ? Q_HALF : Q_HALF - 1'b1) : quo_w[k];
            sol_next[k] = qneg_w[k] ? $signed(-mag) : $signed(mag);
            sat_any = sat_any || sat;
        end
        if (sing_reg[ST_DIVN]) begin
            for (int k = 0; k < 3; k++) sol_next[k] = '0;
            status_next = STATUS_SINGULAR;
        end else if (sat_any) begin
            status_next = STATUS_SATURATED;
        end else begin
            status_next = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_OUT]) begin
            for (int k = 0; k < 3; k++) sol_reg[k] <= sol_next[k];
            status_reg <= status_next;
        end
    end

    assign m_valid        = v_reg[ST_OUT];
    assign m_sol_0        = sol_reg[0];
    assign m_sol_1        = sol_reg[1];
    assign m_sol_2        = sol_reg[2];
    assign m_solve_status = status_reg;

endmodule
`default_nettype wire

/* src/cr3_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cr3_checker
// Port-level checks for the 3x3 Cramer solver, bound to the top level.
// ----------------------------------------------------------------------------
module cr3_checker import cr3_pkg::*; (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic signed [DATA_WIDTH-1:0]  m_sol_0,
    input wire logic signed [DATA_WIDTH-1:0]  m_sol_1,
    input wire logic signed [DATA_WIDTH-1:0]  m_sol_2,
    input wire logic [1:0]                    m_solve_status
);

    // No result may appear in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    // A held result keeps its payload until its transaction completes.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sol_0) && $stable(m_sol_1)
            && $stable(m_sol_2) && $stable(m_solve_status))
        else $error("stalled result changed");

    // A singular system reports zero for every unknown.
    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_solve_status == STATUS_SINGULAR |->
            m_sol_0 == '0 && m_sol_1 == '0 && m_sol_2 == '0)
        else $error("singular result not zero");

    // An empty output stage must take a new transaction.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule

bind cramer_3x3_linear_solver cr3_checker u_cr3_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_sol_0        (m_sol_0),
    .m_sol_1        (m_sol_1),
    .m_sol_2        (m_sol_2),
    .m_solve_status (m_solve_status)
);
`default_nettype wire
